FILE: src/dif_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the duplicate ID filter.
// No dependencies; used by the controller, datapath and top level.
package dif_pkg;

   localparam int ID_WIDTH     = 31;
   localparam int COUNT_WIDTH  = 16;
   localparam int UNIQUE_WIDTH = 7;

   localparam logic [COUNT_WIDTH-1:0] SEEN_MAX = 16'hFFFF;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } dif_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;    // capture request, apply list restart, bump received count
      logic scan;    // walk the stored entries
      logic commit;  // append if new, register the result
   } dif_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic scan_done;  // match found or all stored entries checked
   } dif_status_type;

endpackage

FILE: src/dif_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the duplicate ID filter.
// Depends on dif_pkg for the state, command and status types.
module dif_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output dif_pkg::dif_cmd_type    cmd,
   input  dif_pkg::dif_status_type status
);

   dif_pkg::dif_state_type state_ff;
   dif_pkg::dif_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dif_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dif_pkg::ST_IDLE: begin
            if (start) begin
               state_in = dif_pkg::ST_SCAN;
            end
         end
         dif_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = dif_pkg::ST_IDLE;
            end
         end
         default: state_in = dif_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      busy       = 1'b0;
      cmd.load   = 1'b0;
      cmd.scan   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         dif_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         dif_pkg::ST_SCAN: begin
            busy       = 1'b1;
            cmd.scan   = 1'b1;
            cmd.commit = status.scan_done;
         end
         default: busy = 1'b0;
      endcase
   end

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_commit_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (state_ff == dif_pkg::ST_SCAN))
      else $error("commit outside scan");

   a_commit_ends_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !busy)
      else $error("still busy after commit");

endmodule

FILE: src/dif_datapath.sv
`timescale 1ns / 1ps
// Datapath for the duplicate ID filter: seen-ID memory, scan pointer,
// counters and result registers. Depends on dif_pkg.
module dif_datapath #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dif_pkg::dif_cmd_type                cmd,
   output dif_pkg::dif_status_type             status,
   input  logic [dif_pkg::ID_WIDTH-1:0]        req_id,
   input  logic                                req_first,
   input  logic                                req_last,
   output logic                                rsp_valid,
   output logic [dif_pkg::ID_WIDTH-1:0]        rsp_id_out,
   output logic                                rsp_is_new,
   output logic                                rsp_table_full,
   output logic [dif_pkg::COUNT_WIDTH-1:0]     rsp_seen_count,
   output logic [dif_pkg::UNIQUE_WIDTH-1:0]    rsp_unique_count,
   output logic                                rsp_last_out
);

   localparam int FW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam logic [FW-1:0] DEPTH_FILL = FW'(TABLE_DEPTH);

   logic [dif_pkg::ID_WIDTH-1:0]    seen_table_ff [TABLE_DEPTH];
   logic [dif_pkg::ID_WIDTH-1:0]    rd_data_ff;

   logic [dif_pkg::ID_WIDTH-1:0]    id_ff,     id_in;
   logic                            last_ff,   last_in;
   logic [dif_pkg::COUNT_WIDTH-1:0] count_ff,  count_in;
   logic [FW-1:0]                   fill_ff,   fill_in;
   logic [FW-1:0]                   scan_idx_ff, scan_idx_in;
   logic                            rd_valid_ff, rd_valid_in;
   logic                            hit_ff,    hit_in;

   logic                                rsp_valid_ff,  rsp_valid_in;
   logic                                rsp_is_new_ff, rsp_is_new_in;
   logic                                rsp_full_ff,   rsp_full_in;
   logic [dif_pkg::UNIQUE_WIDTH-1:0]    rsp_unique_ff, rsp_unique_in;

   logic [dif_pkg::COUNT_WIDTH-1:0] count_base;
   logic                            issue;
   logic                            insert;
   logic                            drop;
   logic [FW-1:0]                   fill_after;
   logic [FW+dif_pkg::UNIQUE_WIDTH-1:0] fill_wide;

   assign issue  = cmd.scan && !hit_ff && (scan_idx_ff < fill_ff);
   assign insert = !hit_ff && (fill_ff < DEPTH_FILL);
   assign drop   = !hit_ff && (fill_ff == DEPTH_FILL);
   assign fill_after = insert ? fill_ff + FW'(1) : fill_ff;
   assign fill_wide  = {{dif_pkg::UNIQUE_WIDTH{1'b0}}, fill_after};

   assign status.scan_done = !rd_valid_ff && (hit_ff || (scan_idx_ff >= fill_ff));

   always_comb begin
      count_base    = req_first ? '0 : count_ff;
      id_in         = id_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      scan_idx_in   = scan_idx_ff;
      rd_valid_in   = 1'b0;
      hit_in        = hit_ff;
      rsp_valid_in  = cmd.commit;
      rsp_is_new_in = rsp_is_new_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_unique_in = rsp_unique_ff;

      if (cmd.load) begin
         id_in       = req_id;
         last_in     = req_last;
         count_in    = (count_base == dif_pkg::SEEN_MAX) ? count_base
                                                          : count_base + 16'd1;
         if (req_first) begin
            fill_in = '0;
         end
         scan_idx_in = '0;
         hit_in      = 1'b0;
      end

      if (issue) begin
         scan_idx_in = scan_idx_ff + FW'(1);
         rd_valid_in = 1'b1;
      end

      if (rd_valid_ff && (rd_data_ff == id_ff)) begin
         hit_in = 1'b1;
      end

      if (cmd.commit) begin
         fill_in       = fill_after;
         rsp_is_new_in = !hit_ff;
         rsp_full_in   = drop;
         rsp_unique_in = fill_wide[dif_pkg::UNIQUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         fill_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      last_ff       <= last_in;
      scan_idx_ff   <= scan_idx_in;
      hit_ff        <= hit_in;
      rsp_is_new_ff <= rsp_is_new_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_unique_ff <= rsp_unique_in;
   end

   // Seen-ID memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.commit && insert) begin
         seen_table_ff[fill_ff[IW-1:0]] <= id_ff;
      end
      rd_data_ff <= seen_table_ff[scan_idx_ff[IW-1:0]];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_id_out       = id_ff;
   assign rsp_is_new       = rsp_is_new_ff;
   assign rsp_table_full   = rsp_full_ff;
   assign rsp_seen_count   = count_ff;
   assign rsp_unique_count = rsp_unique_ff;
   assign rsp_last_out     = last_ff;

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_FILL)
      else $error("fill level beyond table depth");

   a_full_implies_new: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> rsp_is_new_ff)
      else $error("dropped entry not flagged new");

   a_read_follows_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> $past(cmd.scan))
      else $error("read data valid without a scan");

   a_commit_no_pending_read: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rd_valid_ff)
      else $error("commit with a read still in flight");

endmodule

FILE: src/duplicate_id_filter_unit.sv
`timescale 1ns / 1ps
// Duplicate ID filter: each request is compared against the F stored unique IDs (F at most
// TABLE_DEPTH); a new ID is checked against all of them, while a repeat ends the scan once
// its matching entry has been read. The scan makes one memory read per cycle. The next
// request is taken in the strobe cycle. The receiver cannot stall.
// Synchronous active-high reset empties the table and clears the received count and fill level.
module duplicate_id_filter_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // request transfer: taken when start is high and busy is low
   input  logic                                start,
   output logic                                busy,
   input  logic [dif_pkg::ID_WIDTH-1:0]        req_id,
   input  logic                                req_first,
   input  logic                                req_last,
   // result transfer: valid for exactly one cycle per request
   output logic                                rsp_valid,
   output logic [dif_pkg::ID_WIDTH-1:0]        rsp_id_out,
   output logic                                rsp_is_new,
   output logic                                rsp_table_full,
   output logic [dif_pkg::COUNT_WIDTH-1:0]     rsp_seen_count,
   output logic [dif_pkg::UNIQUE_WIDTH-1:0]    rsp_unique_count,
   output logic                                rsp_last_out
);

   // Controller and datapath talk only through these two bundles.
   dif_pkg::dif_cmd_type    cmd;
   dif_pkg::dif_status_type status;

   // The controller sequences load, scan and commit for each request transfer.
   dif_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // The datapath holds the compact seen-ID table, walks it one entry per cycle,
   // keeps the running counts and drives the registered result.
   dif_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_id           (req_id),
      .req_first        (req_first),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_id_out       (rsp_id_out),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full),
      .rsp_seen_count   (rsp_seen_count),
      .rsp_unique_count (rsp_unique_count),
      .rsp_last_out     (rsp_last_out)
   );

   // Result strobes of successive requests never run together.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // Every result counts at least its own request.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_seen_count != '0))
      else $error("result with zero received count");

   // A duplicate can only be found in a table that holds something.
   a_dup_keeps_unique: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_new && $past(rsp_valid, 2) == 1'b0 && !busy)
      |-> (rsp_unique_count != '0))
      else $error("duplicate reported with empty table");

endmodule
